[hdl/modbus_relay_request_handler_unit_macros.svh]
// Assertion macros for the Modbus relay request handler.
// Used by the top level only; no other dependencies.
`ifndef MODBUS_RELAY_REQUEST_HANDLER_UNIT_MACROS_SVH
`define MODBUS_RELAY_REQUEST_HANDLER_UNIT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define MRRH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define MRRH_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `MRRH_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

[hdl/modrrh_pkg.sv]
// Shared types and constants for the Modbus relay request handler.
// No dependencies.
package modrrh_pkg;

    localparam logic [7:0] FC_READ_COILS  = 8'd1;
    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT  = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_HOLD  = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS = 8'd15;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam int IREG_COUNT = 6;
    localparam int HOLD_COUNT = 1;
    localparam logic [15:0] HOLD_SEQ_ADDR = 16'd0;

    localparam int IREG_IDX_W = 3;
    localparam logic [IREG_IDX_W-1:0] IREG_RELAYS  = 3'd0;
    localparam logic [IREG_IDX_W-1:0] IREG_FAULTS  = 3'd1;
    localparam logic [IREG_IDX_W-1:0] IREG_UP_LO   = 3'd2;
    localparam logic [IREG_IDX_W-1:0] IREG_UP_HI   = 3'd3;
    localparam logic [IREG_IDX_W-1:0] IREG_FW      = 3'd4;
    localparam logic [IREG_IDX_W-1:0] IREG_SEQ     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILL_FUNC  = 2'd1,
        ST_ILL_ADDR  = 2'd2,
        ST_ILL_VALUE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_EXCEPTION,
        OP_RD_COILS,
        OP_RD_HOLD,
        OP_RD_INPUT,
        OP_WR_COIL,
        OP_WR_HOLD,
        OP_WR_COILS
    } t_op;

    typedef struct packed {
        t_op         op;
        t_status     status;
        logic [15:0] addr;
        logic [15:0] value;
        logic [7:0]  resp_bc;
        logic [15:0] mask;
        logic [15:0] data;
        logic [15:0] faults;
        logic [31:0] uptime;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hdl/modrrh_req_if.sv]
// Request channel: valid/ready handshake with the request PDU fields.
// No dependencies.
interface modrrh_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  func;
    logic [15:0] start_or_address;
    logic [15:0] count_or_value;
    logic [7:0]  byte_count;
    logic [15:0] coil_data;
    logic [15:0] fault_bits;
    logic [31:0] uptime_seconds;

    modport source (
        output valid, func, start_or_address, count_or_value, byte_count,
               coil_data, fault_bits, uptime_seconds,
        input  ready
    );
    modport sink (
        input  valid, func, start_or_address, count_or_value, byte_count,
               coil_data, fault_bits, uptime_seconds,
        output ready
    );
endinterface

[hdl/modrrh_rsp_if.sv]
// Response channel: valid/ready handshake with two result words (word_a, word_b) per transfer.
// No dependencies.
interface modrrh_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  resp_byte_count;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        last;

    modport source (
        output valid, status, resp_byte_count, word_a, word_b, last,
        input  ready
    );
    modport sink (
        input  valid, status, resp_byte_count, word_a, word_b, last,
        output ready
    );
endinterface

[hdl/modrrh_front.sv]
// Front end: accepts requests, validates them and builds a command.
// Depends on modrrh_pkg and modrrh_req_if.
module modrrh_front
    import modrrh_pkg::*;
#(
    parameter int NUM_COILS = 6
) (
    modrrh_req_if.sink i_req,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [16:0] w_end;
    logic        w_cnt_zero;
    logic [15:0] w_mb_bytes;
    logic [15:0] w_mask;

    assign i_req.ready = !i_q_status.full;
    assign o_push      = i_req.valid && !i_q_status.full;

    always_comb begin
        w_end      = 17'(i_req.start_or_address) + 17'(i_req.count_or_value);
        w_cnt_zero = (i_req.count_or_value == 16'd0);
        w_mb_bytes = ((i_req.count_or_value - 16'd1) >> 3) + 16'd1;
        w_mask     = 16'((17'd1 << i_req.count_or_value[4:0]) - 17'd1);

        o_cmd.op      = OP_EXCEPTION;
        o_cmd.status  = ST_OK;
        o_cmd.addr    = i_req.start_or_address;
        o_cmd.value   = i_req.count_or_value;
        o_cmd.resp_bc = 8'd0;
        o_cmd.mask    = w_mask;
        o_cmd.data    = i_req.coil_data;
        o_cmd.faults  = i_req.fault_bits;
        o_cmd.uptime  = i_req.uptime_seconds;

        unique case (i_req.func)
            FC_READ_COILS: begin
                if (w_cnt_zero || w_end > 17'(NUM_COILS)) begin
                    o_cmd.status = ST_ILL_ADDR;
                end else begin
                    o_cmd.op      = OP_RD_COILS;
                    o_cmd.resp_bc = 8'((17'(i_req.count_or_value) + 17'd7) >> 3);
                end
            end
            FC_READ_HOLD: begin
                if (w_cnt_zero || w_end > 17'(HOLD_COUNT)) begin
                    o_cmd.status = ST_ILL_ADDR;
                end else begin
                    o_cmd.op      = OP_RD_HOLD;
                    o_cmd.resp_bc = 8'({i_req.count_or_value, 1'b0});
                end
            end
            FC_READ_INPUT: begin
                if (w_cnt_zero || w_end > 17'(IREG_COUNT)) begin
                    o_cmd.status = ST_ILL_ADDR;
                end else begin
                    o_cmd.op      = OP_RD_INPUT;
                    o_cmd.resp_bc = 8'({i_req.count_or_value, 1'b0});
                end
            end
            FC_WRITE_COIL: begin
                if (17'(i_req.start_or_address) >= 17'(NUM_COILS)) begin
                    o_cmd.status = ST_ILL_ADDR;
                end else if (i_req.count_or_value != COIL_ON
                             && i_req.count_or_value != COIL_OFF) begin
                    o_cmd.status = ST_ILL_VALUE;
                end else begin
                    o_cmd.op = OP_WR_COIL;
                end
            end
            FC_WRITE_HOLD: begin
                if (i_req.start_or_address != HOLD_SEQ_ADDR) begin
                    o_cmd.status = ST_ILL_ADDR;
                end else begin
                    o_cmd.op = OP_WR_HOLD;
                end
            end
            FC_WRITE_COILS: begin
                if (w_cnt_zero || w_end > 17'(NUM_COILS)) begin
                    o_cmd.status = ST_ILL_ADDR;
                end else if ({8'd0, i_req.byte_count} != w_mb_bytes) begin
                    o_cmd.status = ST_ILL_VALUE;
                end else begin
                    o_cmd.op = OP_WR_COILS;
                end
            end
            default: begin
                o_cmd.status = ST_ILL_FUNC;
            end
        endcase
    end

endmodule

[hdl/modrrh_queue.sv]
// Two-entry command queue between front and back end.
// Depends on modrrh_pkg.
module modrrh_queue
    import modrrh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_push_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       r_slot0;
    t_cmd       r_slot1;

    assign o_head          = r_slot0;
    assign o_status.full   = (r_cnt == 2'd2);
    assign o_status.empty  = (r_cnt == 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_pop) begin
            r_slot0 <= (r_cnt == 2'd2) ? r_slot1 : i_push_cmd;
            if (i_push) begin
                r_slot1 <= i_push_cmd;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_slot0 <= i_push_cmd;
            end else begin
                r_slot1 <= i_push_cmd;
            end
        end
    end

endmodule

[hdl/modrrh_back.sv]
// Back end: executes commands, holds relay/sequence/firmware state, emits results.
// Depends on modrrh_pkg and modrrh_rsp_if.
module modrrh_back
    import modrrh_pkg::*;
#(
    parameter int NUM_COILS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  t_cmd              i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    modrrh_rsp_if.source      o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                  r_state;
    t_cmd                    r_cmd;
    logic [IREG_IDX_W-1:0]   r_idx;
    logic [IREG_IDX_W-1:0]   r_left;
    logic [NUM_COILS-1:0]    r_relay;
    logic [NUM_COILS-1:0]    n_relay;
    logic [15:0]             r_seq;
    logic [15:0]             n_seq;
    logic [15:0]             r_fw;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [7:0]              r_out_bc;
    logic [15:0]             r_out_a;
    logic [15:0]             r_out_b;
    logic                    r_out_last;

    logic                    w_can_load;
    logic                    w_last;
    logic [3:0]              w_shamt;
    logic [15:0]             w_relay16;
    logic [15:0]             w_onehot;
    logic [15:0]             w_field;
    logic [15:0]             w_relay_nx;
    logic [15:0]             w_ireg;
    t_status                 w_status;
    logic [7:0]              w_bc;
    logic [15:0]             w_a;
    logic [15:0]             w_b;

    assign o_pop      = (r_state == S_IDLE) && !i_q_status.empty;
    assign w_can_load = !r_out_valid || o_rsp.ready;
    assign w_last     = (r_left == IREG_IDX_W'(1));

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.resp_byte_count = r_out_bc;
    assign o_rsp.word_a          = r_out_a;
    assign o_rsp.word_b          = r_out_b;
    assign o_rsp.last            = r_out_last;

    always_comb begin
        unique case (r_idx)
            IREG_RELAYS: w_ireg = w_relay16;
            IREG_FAULTS: w_ireg = r_cmd.faults;
            IREG_UP_LO:  w_ireg = r_cmd.uptime[15:0];
            IREG_UP_HI:  w_ireg = r_cmd.uptime[31:16];
            IREG_FW:     w_ireg = r_fw;
            IREG_SEQ:    w_ireg = r_seq;
            default:     w_ireg = 16'd0;
        endcase
    end

    always_comb begin
        w_relay16  = 16'(r_relay);
        w_shamt    = r_cmd.addr[3:0];
        w_onehot   = 16'd1 << w_shamt;
        w_field    = r_cmd.mask << w_shamt;
        w_relay_nx = w_relay16;
        n_seq      = r_seq;
        w_status   = ST_OK;
        w_bc       = 8'd0;
        w_a        = 16'd0;
        w_b        = 16'd0;

        unique case (r_cmd.op)
            OP_EXCEPTION: begin
                w_status = r_cmd.status;
            end
            OP_RD_COILS: begin
                w_bc = r_cmd.resp_bc;
                w_a  = (w_relay16 >> w_shamt) & r_cmd.mask;
            end
            OP_RD_HOLD: begin
                w_bc = r_cmd.resp_bc;
                w_a  = r_seq;
            end
            OP_RD_INPUT: begin
                w_bc = r_cmd.resp_bc;
                w_a  = w_ireg;
            end
            OP_WR_COIL: begin
                w_a = r_cmd.addr;
                w_b = r_cmd.value;
                if (r_cmd.value == COIL_ON) begin
                    w_relay_nx = w_relay16 | w_onehot;
                end else begin
                    w_relay_nx = w_relay16 & ~w_onehot;
                end
            end
            OP_WR_HOLD: begin
                w_a   = r_cmd.addr;
                w_b   = r_cmd.value;
                n_seq = r_cmd.value;
            end
            OP_WR_COILS: begin
                w_a        = r_cmd.addr;
                w_b        = r_cmd.value;
                w_relay_nx = (w_relay16 & ~w_field) | ((r_cmd.data << w_shamt) & w_field);
            end
            default: begin
                w_status = r_cmd.status;
            end
        endcase
        n_relay = w_relay_nx[NUM_COILS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_relay     <= '0;
            r_seq       <= 16'd0;
            r_fw        <= 16'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_fw <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_rsp.ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (!i_q_status.empty) begin
                        r_cmd   <= i_head;
                        r_state <= S_RUN;
                        if (i_head.op == OP_RD_INPUT) begin
                            r_idx  <= i_head.addr[IREG_IDX_W-1:0];
                            r_left <= i_head.value[IREG_IDX_W-1:0];
                        end else begin
                            r_idx  <= '0;
                            r_left <= IREG_IDX_W'(1);
                        end
                    end
                end
                S_RUN: begin
                    if (w_can_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= w_status;
                        r_out_bc     <= w_bc;
                        r_out_a      <= w_a;
                        r_out_b      <= w_b;
                        r_out_last   <= w_last;
                        r_relay      <= n_relay;
                        r_seq        <= n_seq;
                        r_idx        <= r_idx + IREG_IDX_W'(1);
                        r_left       <= r_left - IREG_IDX_W'(1);
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

endmodule

[hdl/modbus_relay_request_handler_unit.sv]
// Modbus relay request handler: front end, two-entry queue, back end.
// Each request yields one result, or 1..6 results for input register reads;
// the back end takes the next command only after the last result of the current one.
// Its sequencer emits one result per cycle while the response channel is ready.
// Reset (synchronous, active low): relays off, sequence word and firmware
// version cleared, queue emptied, no result pending.
`include "modbus_relay_request_handler_unit_macros.svh"

module modbus_relay_request_handler_unit
    import modrrh_pkg::*;
#(
    parameter int NUM_COILS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    modrrh_req_if.sink    i_req,
    modrrh_rsp_if.source  o_rsp,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data
);

    logic      w_push;
    logic      w_pop;
    t_cmd      w_push_cmd;
    t_cmd      w_head;
    t_q_status w_q_status;

    modrrh_front #(
        .NUM_COILS (NUM_COILS)
    ) u_front (
        .i_req      (i_req),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    modrrh_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_status   (w_q_status)
    );

    modrrh_back #(
        .NUM_COILS (NUM_COILS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_rsp         (o_rsp)
    );

    `MRRH_ASSERT(a_burst_continues, i_clk, i_rst_n, o_rsp.valid && o_rsp.ready && !o_rsp.last |=> o_rsp.valid, "register read burst stalled after a non-final transfer")
    `MRRH_ASSERT_NEVER(a_nonlast_is_read, i_clk, i_rst_n, o_rsp.valid && !o_rsp.last && (o_rsp.status != ST_OK || o_rsp.resp_byte_count == 8'd0), "non-final result outside a register read")
    `MRRH_ASSERT_NEVER(a_exception_clean, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_OK && (o_rsp.word_a != 16'd0 || o_rsp.word_b != 16'd0 || o_rsp.resp_byte_count != 8'd0 || !o_rsp.last), "exception result carries data")

endmodule
